// ===== sv/mrac_pkg.sv =====
`default_nettype none

package mrac_pkg;

   // channel and port widths
   localparam int REQ_W      = 144;
   localparam int RSP_W      = 72;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // gain bank
   localparam int NUM_GAINS  = 8;
   localparam int GAIN_IDX_W = 3;
   localparam int GAIN_W     = 16;

   // payload and datapath widths
   localparam int STICK_W  = 12;
   localparam int SENSOR_W = 16;
   localparam int OFF_W    = 13;  // stick minus center or throttle base, signed
   localparam int OPA_W    = 18;  // multiplier operand A, holds |pitch|+|roll|
   localparam int PROD_W   = 34;
   localparam int SUM_W    = 42;  // covers integral plus product with headroom
   localparam int INT_W    = 40;
   localparam int DRV_W    = 16;
   localparam int FRAC_W   = 8;

   // sequencer program layout
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] AXIS_START = 4'd5;
   localparam logic [STEP_W-1:0] LAST_STEP  = 4'd11;

   // pulse width thresholds in microseconds
   localparam logic [STICK_W-1:0] STICK_CENTER    = 12'd1500;
   localparam logic [STICK_W-1:0] THROTTLE_BASE   = 12'd1150;
   localparam logic [STICK_W-1:0] INT_CLEAR_LIMIT = 12'd1200;
   localparam logic [STICK_W-1:0] ARM_LIMIT       = 12'd1500;

   // saturation limits in accumulator width, drive limits in drive width
   localparam logic signed [SUM_W-1:0] S16_MAX = SUM_W'(64'sd32767);
   localparam logic signed [SUM_W-1:0] S16_MIN = SUM_W'(-64'sd32768);
   localparam logic signed [SUM_W-1:0] S40_MAX = SUM_W'(64'sd549755813887);
   localparam logic signed [SUM_W-1:0] S40_MIN = SUM_W'(-64'sd549755813888);
   localparam logic signed [DRV_W-1:0] DRV_MAX = 16'sh7FFF;
   localparam logic signed [DRV_W-1:0] DRV_MIN = 16'sh8000;

   typedef logic [NUM_GAINS-1:0][GAIN_W-1:0] gain_bank_type;

   typedef enum logic [2:0] {
      GAIN_THROTTLE,
      GAIN_ALTITUDE,
      GAIN_YAW_STICK,
      GAIN_YAW_RATE,
      GAIN_STICK,
      GAIN_RATE,
      GAIN_ANGLE,
      GAIN_INTEGRAL
   } gain_sel_type;

   typedef enum logic [2:0] {
      MA_THR_OFF,
      MA_ABS_SUM,
      MA_YAW_OFF,
      MA_YAW_RATE,
      MA_STICK_OFF,
      MA_RATE,
      MA_ANGLE,
      MA_TMP
   } ma_sel_type;

   typedef enum logic [1:0] {
      BASE_ZERO,
      BASE_IDLE,
      BASE_TMP,
      BASE_INT
   } base_sel_type;

   typedef enum logic [0:0] {
      ADD_PROD,
      ADD_INT
   } addend_sel_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_TMP,
      DST_THR,
      DST_YAW,
      DST_DRIVE,
      DST_INT
   } dst_sel_type;

   typedef enum logic [0:0] {
      FLOW_NEXT,
      FLOW_AXIS_END
   } flow_type;

   typedef enum logic [0:0] {
      AXIS_PITCH,
      AXIS_ROLL
   } axis_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      ma_sel_type     ma_sel;
      gain_sel_type   gain_sel;
      base_sel_type   base_sel;
      addend_sel_type addend_sel;
      logic           add_neg;
      dst_sel_type    dst_sel;
      flow_type       flow;
   } uc_type;

   localparam uc_type UC_NOP = '{
      ma_sel:     MA_THR_OFF,
      gain_sel:   GAIN_THROTTLE,
      base_sel:   BASE_ZERO,
      addend_sel: ADD_PROD,
      add_neg:    1'b0,
      dst_sel:    DST_NONE,
      flow:       FLOW_NEXT
   };

   typedef struct packed {
      uc_type   uc;
      axis_type axis;
      logic     capture;
      logic     load;
      logic     idle;
   } ctl_type;

   typedef struct packed {
      logic [STICK_W-1:0]         roll_stick;
      logic [STICK_W-1:0]         pitch_stick;
      logic [STICK_W-1:0]         throttle_stick;
      logic [STICK_W-1:0]         yaw_stick;
      logic [STICK_W-1:0]         arm_switch;
      logic signed [SENSOR_W-1:0] pitch_angle;
      logic signed [SENSOR_W-1:0] roll_angle;
      logic signed [SENSOR_W-1:0] yaw_rate;
      logic signed [SENSOR_W-1:0] pitch_rate;
      logic signed [SENSOR_W-1:0] roll_rate;
   } item_type;

   typedef struct packed {
      logic                    armed;
      logic signed [DRV_W-1:0] throttle_drive;
      logic signed [DRV_W-1:0] yaw_drive;
      logic signed [DRV_W-1:0] pitch_drive;
      logic signed [DRV_W-1:0] roll_drive;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/mrac_seq.sv =====
`default_nettype none

module mrac_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              out_free,
   output mrac_pkg::ctl_type      ctl
);

   mrac_pkg::seq_state_type state_ff, state_in;
   logic [mrac_pkg::STEP_W-1:0] step_ff, step_in;
   mrac_pkg::axis_type axis_ff, axis_in;
   mrac_pkg::uc_type uc;

   // control store: steps 0..4 throttle and yaw, 5..11 one tilt axis (run twice)
   function automatic mrac_pkg::uc_type ucode(input logic [mrac_pkg::STEP_W-1:0] step);
      mrac_pkg::uc_type w;
      w = mrac_pkg::UC_NOP;
      case (step)
         4'd0: begin
            w.ma_sel   = mrac_pkg::MA_THR_OFF;
            w.gain_sel = mrac_pkg::GAIN_THROTTLE;
         end
         4'd1: begin
            w.ma_sel   = mrac_pkg::MA_ABS_SUM;
            w.gain_sel = mrac_pkg::GAIN_ALTITUDE;
            w.base_sel = mrac_pkg::BASE_IDLE;
            w.dst_sel  = mrac_pkg::DST_TMP;
         end
         4'd2: begin
            w.ma_sel   = mrac_pkg::MA_YAW_OFF;
            w.gain_sel = mrac_pkg::GAIN_YAW_STICK;
            w.base_sel = mrac_pkg::BASE_TMP;
            w.dst_sel  = mrac_pkg::DST_THR;
         end
         4'd3: begin
            w.ma_sel   = mrac_pkg::MA_YAW_RATE;
            w.gain_sel = mrac_pkg::GAIN_YAW_RATE;
            w.dst_sel  = mrac_pkg::DST_TMP;
         end
         4'd4: begin
            w.base_sel = mrac_pkg::BASE_TMP;
            w.add_neg  = 1'b1;
            w.dst_sel  = mrac_pkg::DST_YAW;
         end
         4'd5: begin
            w.ma_sel   = mrac_pkg::MA_STICK_OFF;
            w.gain_sel = mrac_pkg::GAIN_STICK;
         end
         4'd6: begin
            w.ma_sel   = mrac_pkg::MA_RATE;
            w.gain_sel = mrac_pkg::GAIN_RATE;
            w.dst_sel  = mrac_pkg::DST_TMP;
         end
         4'd7: begin
            w.ma_sel   = mrac_pkg::MA_ANGLE;
            w.gain_sel = mrac_pkg::GAIN_ANGLE;
            w.base_sel = mrac_pkg::BASE_TMP;
            w.add_neg  = 1'b1;
            w.dst_sel  = mrac_pkg::DST_TMP;
         end
         4'd8: begin
            w.base_sel = mrac_pkg::BASE_TMP;
            w.add_neg  = 1'b1;
            w.dst_sel  = mrac_pkg::DST_TMP;
         end
         4'd9: begin
            w.ma_sel   = mrac_pkg::MA_TMP;
            w.gain_sel = mrac_pkg::GAIN_INTEGRAL;
         end
         4'd10: begin
            w.base_sel = mrac_pkg::BASE_INT;
            w.dst_sel  = mrac_pkg::DST_INT;
         end
         4'd11: begin
            w.base_sel   = mrac_pkg::BASE_TMP;
            w.addend_sel = mrac_pkg::ADD_INT;
            w.dst_sel    = mrac_pkg::DST_DRIVE;
            w.flow       = mrac_pkg::FLOW_AXIS_END;
         end
         default: begin
            w = mrac_pkg::UC_NOP;
         end
      endcase
      return w;
   endfunction

   assign uc = ucode(step_ff);

   // next state, step counter and axis
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      case (state_ff)
         mrac_pkg::SEQ_IDLE: begin
            if (start) begin
               state_in = mrac_pkg::SEQ_RUN;
               step_in  = '0;
               axis_in  = mrac_pkg::AXIS_PITCH;
            end
         end
         mrac_pkg::SEQ_RUN: begin
            if (uc.flow == mrac_pkg::FLOW_AXIS_END) begin
               if (axis_ff == mrac_pkg::AXIS_PITCH) begin
                  step_in = mrac_pkg::AXIS_START;
                  axis_in = mrac_pkg::AXIS_ROLL;
               end else begin
                  state_in = mrac_pkg::SEQ_DONE;
                  step_in  = '0;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         mrac_pkg::SEQ_DONE: begin
            if (out_free) begin
               state_in = mrac_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = mrac_pkg::SEQ_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctl.uc      = (state_ff == mrac_pkg::SEQ_RUN) ? uc : mrac_pkg::UC_NOP;
      ctl.axis    = axis_ff;
      ctl.capture = start && (state_ff == mrac_pkg::SEQ_IDLE);
      ctl.load    = (state_ff == mrac_pkg::SEQ_DONE) && out_free;
      ctl.idle    = (state_ff == mrac_pkg::SEQ_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrac_pkg::SEQ_IDLE;
         step_ff  <= '0;
         axis_ff  <= mrac_pkg::AXIS_PITCH;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         axis_ff  <= axis_in;
      end
   end

   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrac_pkg::SEQ_RUN) |-> (step_ff <= mrac_pkg::LAST_STEP))
      else $error("step counter ran past the program");

   a_axis_loop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrac_pkg::SEQ_RUN && step_ff == mrac_pkg::LAST_STEP
         && axis_ff == mrac_pkg::AXIS_PITCH)
      |=> (state_ff == mrac_pkg::SEQ_RUN && step_ff == mrac_pkg::AXIS_START
         && axis_ff == mrac_pkg::AXIS_ROLL))
      else $error("pitch pass did not loop back for roll");

endmodule

`default_nettype wire

// ===== sv/mrac_dp.sv =====
`default_nettype none

module mrac_dp #(
   parameter int IDLE_THROTTLE = 1000
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mrac_pkg::ctl_type       ctl,
   input  wire mrac_pkg::item_type      item,
   input  wire mrac_pkg::gain_bank_type gain,
   output mrac_pkg::result_type         result
);

   localparam logic signed [mrac_pkg::SUM_W-1:0] IdleBase =
      mrac_pkg::SUM_W'(IDLE_THROTTLE * 256);

   // captured item
   logic signed [mrac_pkg::OFF_W-1:0]    thr_off_ff, yaw_off_ff, pitch_off_ff, roll_off_ff;
   logic signed [mrac_pkg::SENSOR_W-1:0] pitch_ang_ff, roll_ang_ff;
   logic signed [mrac_pkg::SENSOR_W-1:0] yaw_rate_ff, pitch_rate_ff, roll_rate_ff;
   logic signed [mrac_pkg::OPA_W-1:0]    abs_sum_ff;
   logic                                 clear_ff, armed_ff;

   logic [mrac_pkg::SENSOR_W:0]        abs_p, abs_r;
   logic signed [mrac_pkg::OPA_W-1:0]  abs_sum_in;

   // working registers
   logic signed [mrac_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [mrac_pkg::DRV_W-1:0]  tmp_ff, thr_ff, yaw_ff, pd_ff, rd_ff;
   logic signed [mrac_pkg::INT_W-1:0]  pint_ff, rint_ff, int_in;

   logic signed [mrac_pkg::OPA_W-1:0]  opa;
   logic signed [mrac_pkg::GAIN_W-1:0] opb;
   logic signed [mrac_pkg::INT_W-1:0]  int_sel;
   logic signed [mrac_pkg::SUM_W-1:0]  tmp_ext, base, addend, sum, quo, quo_tz;
   logic signed [mrac_pkg::DRV_W-1:0]  a16;
   logic                               rnd;

   always_comb begin
      abs_p = (item.pitch_angle < 0) ? -(17'(item.pitch_angle)) : 17'(item.pitch_angle);
      abs_r = (item.roll_angle < 0) ? -(17'(item.roll_angle)) : 17'(item.roll_angle);
      abs_sum_in = mrac_pkg::OPA_W'(abs_p) + mrac_pkg::OPA_W'(abs_r);
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         thr_off_ff    <= $signed({1'b0, item.throttle_stick})
                          - $signed({1'b0, mrac_pkg::THROTTLE_BASE});
         yaw_off_ff    <= $signed({1'b0, item.yaw_stick})
                          - $signed({1'b0, mrac_pkg::STICK_CENTER});
         pitch_off_ff  <= $signed({1'b0, item.pitch_stick})
                          - $signed({1'b0, mrac_pkg::STICK_CENTER});
         roll_off_ff   <= $signed({1'b0, item.roll_stick})
                          - $signed({1'b0, mrac_pkg::STICK_CENTER});
         pitch_ang_ff  <= item.pitch_angle;
         roll_ang_ff   <= item.roll_angle;
         yaw_rate_ff   <= item.yaw_rate;
         pitch_rate_ff <= item.pitch_rate;
         roll_rate_ff  <= item.roll_rate;
         abs_sum_ff    <= abs_sum_in;
         clear_ff      <= item.throttle_stick < mrac_pkg::INT_CLEAR_LIMIT;
         armed_ff      <= item.arm_switch > mrac_pkg::ARM_LIMIT;
      end
   end

   // multiply stage
   always_comb begin
      case (ctl.uc.ma_sel)
         mrac_pkg::MA_THR_OFF:   opa = mrac_pkg::OPA_W'(thr_off_ff);
         mrac_pkg::MA_ABS_SUM:   opa = abs_sum_ff;
         mrac_pkg::MA_YAW_OFF:   opa = mrac_pkg::OPA_W'(yaw_off_ff);
         mrac_pkg::MA_YAW_RATE:  opa = mrac_pkg::OPA_W'(yaw_rate_ff);
         mrac_pkg::MA_STICK_OFF: opa = (ctl.axis == mrac_pkg::AXIS_ROLL)
                                       ? mrac_pkg::OPA_W'(roll_off_ff)
                                       : mrac_pkg::OPA_W'(pitch_off_ff);
         mrac_pkg::MA_RATE:      opa = (ctl.axis == mrac_pkg::AXIS_ROLL)
                                       ? mrac_pkg::OPA_W'(roll_rate_ff)
                                       : mrac_pkg::OPA_W'(pitch_rate_ff);
         mrac_pkg::MA_ANGLE:     opa = (ctl.axis == mrac_pkg::AXIS_ROLL)
                                       ? mrac_pkg::OPA_W'(roll_ang_ff)
                                       : mrac_pkg::OPA_W'(pitch_ang_ff);
         mrac_pkg::MA_TMP:       opa = mrac_pkg::OPA_W'(tmp_ff);
         default:                opa = '0;
      endcase
      opb     = $signed(gain[ctl.uc.gain_sel]);
      prod_in = opa * opb;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // accumulate stage: base +/- addend, then Q.8 -> integer toward zero, sat16; integral sat40 or cleared
   always_comb begin
      int_sel = (ctl.axis == mrac_pkg::AXIS_ROLL) ? rint_ff : pint_ff;
      tmp_ext = mrac_pkg::SUM_W'(tmp_ff);
      case (ctl.uc.base_sel)
         mrac_pkg::BASE_ZERO: base = '0;
         mrac_pkg::BASE_IDLE: base = IdleBase;
         mrac_pkg::BASE_TMP:  base = tmp_ext <<< mrac_pkg::FRAC_W;
         mrac_pkg::BASE_INT:  base = mrac_pkg::SUM_W'(int_sel);
         default:             base = '0;
      endcase
      addend = (ctl.uc.addend_sel == mrac_pkg::ADD_INT) ? mrac_pkg::SUM_W'(int_sel)
                                                        : mrac_pkg::SUM_W'(prod_ff);
      sum = ctl.uc.add_neg ? (base - addend) : (base + addend);

      rnd    = sum[mrac_pkg::SUM_W-1] && (|sum[mrac_pkg::FRAC_W-1:0]);
      quo    = sum >>> mrac_pkg::FRAC_W;
      quo_tz = quo + {{(mrac_pkg::SUM_W-1){1'b0}}, rnd};
      if (quo_tz > mrac_pkg::S16_MAX) begin
         a16 = mrac_pkg::DRV_MAX;
      end else if (quo_tz < mrac_pkg::S16_MIN) begin
         a16 = mrac_pkg::DRV_MIN;
      end else begin
         a16 = quo_tz[mrac_pkg::DRV_W-1:0];
      end

      if (clear_ff) begin
         int_in = '0;
      end else if (sum > mrac_pkg::S40_MAX) begin
         int_in = mrac_pkg::S40_MAX[mrac_pkg::INT_W-1:0];
      end else if (sum < mrac_pkg::S40_MIN) begin
         int_in = mrac_pkg::S40_MIN[mrac_pkg::INT_W-1:0];
      end else begin
         int_in = sum[mrac_pkg::INT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.uc.dst_sel)
         mrac_pkg::DST_TMP: tmp_ff <= a16;
         mrac_pkg::DST_THR: thr_ff <= a16;
         mrac_pkg::DST_YAW: yaw_ff <= a16;
         mrac_pkg::DST_DRIVE: begin
            if (ctl.axis == mrac_pkg::AXIS_ROLL) begin
               rd_ff <= a16;
            end else begin
               pd_ff <= a16;
            end
         end
         default: begin
         end
      endcase
   end

   // running integrals
   always_ff @(posedge clock) begin
      if (reset) begin
         pint_ff <= '0;
         rint_ff <= '0;
      end else if (ctl.uc.dst_sel == mrac_pkg::DST_INT) begin
         if (ctl.axis == mrac_pkg::AXIS_ROLL) begin
            rint_ff <= int_in;
         end else begin
            pint_ff <= int_in;
         end
      end
   end

   assign result.armed          = armed_ff;
   assign result.throttle_drive = thr_ff;
   assign result.yaw_drive      = yaw_ff;
   assign result.pitch_drive    = pd_ff;
   assign result.roll_drive     = rd_ff;

endmodule

`default_nettype wire

// ===== sv/multirotor_attitude_controller.sv =====
// Multirotor attitude controller: one control-loop iteration per transfer.
// req channel: one transfer carries the five radio pulse widths, pitch and roll
//   angles and three gyro rates. req_tready is high only while the sequencer is
//   idle; a new item is taken in the cycle after the previous result is handed to
//   the output register.
// rsp channel: armed flag, throttle, yaw, pitch and roll drives, held in an
//   output register until taken, so the next item can run while it waits.
// csr port: eight Q8.8 gains at byte addresses 0x00..0x1C; write only while idle.
// Datapath: a single shared 18x16 multiplier and a 42-bit accumulator are driven
//   by a 12-word control store. Throttle and yaw take 5 steps, the tilt-axis
//   routine takes 7 steps and runs once for pitch, once for roll (19 steps).
//   Each product is registered before the accumulator adds it.
// Reset: gains and both integrals return to zero, sequencer goes idle, rsp
//   channel empties. Integrals also clear on any item with throttle below 1200.
// Stall: if rsp_tready stays low, the finished item waits in the sequencer and
//   no new item is accepted until the output register frees.
`default_nettype none

module multirotor_attitude_controller #(
   parameter int IDLE_THROTTLE = 1000
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // roll_stick[11:0], pitch_stick[23:12], throttle_stick[35:24], yaw_stick[47:36],
   // arm_switch[59:48], pitch_angle[75:60], roll_angle[91:76], yaw_rate[107:92],
   // pitch_rate[123:108], roll_rate[139:124], zero pad [143:140]
   input  wire logic [mrac_pkg::REQ_W-1:0]        req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // armed[0], throttle_drive[16:1], yaw_drive[32:17], pitch_drive[48:33],
   // roll_drive[64:49], zero pad [71:65]
   output logic [mrac_pkg::RSP_W-1:0]             rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [mrac_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [mrac_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mrac_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   mrac_pkg::ctl_type       ctl;
   mrac_pkg::item_type      item;
   mrac_pkg::result_type    result;
   mrac_pkg::gain_bank_type gain_ff, gain_in;

   logic                             req_xfer, out_free, csr_wr;
   logic [mrac_pkg::GAIN_IDX_W-1:0]  csr_idx;
   logic                             rsp_tvalid_ff, rsp_tvalid_in;
   logic [mrac_pkg::RSP_W-1:0]       rsp_tdata_ff;

   // ---- input channel ----
   assign req_tready = ctl.idle;
   assign req_xfer   = req_tvalid && req_tready;

   assign item.roll_stick     = req_tdata[11:0];
   assign item.pitch_stick    = req_tdata[23:12];
   assign item.throttle_stick = req_tdata[35:24];
   assign item.yaw_stick      = req_tdata[47:36];
   assign item.arm_switch     = req_tdata[59:48];
   assign item.pitch_angle    = req_tdata[75:60];
   assign item.roll_angle     = req_tdata[91:76];
   assign item.yaw_rate       = req_tdata[107:92];
   assign item.pitch_rate     = req_tdata[123:108];
   assign item.roll_rate      = req_tdata[139:124];

   // ---- gain registers ----
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[mrac_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = mrac_pkg::CSR_DATA_W'($signed(gain_ff[csr_idx]));

   always_comb begin
      gain_in = gain_ff;
      if (csr_wr) begin
         gain_in[csr_idx] = csr_pwdata[mrac_pkg::GAIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // ---- sequencer and datapath ----
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   mrac_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_xfer),
      .out_free (out_free),
      .ctl      (ctl)
   );

   mrac_dp #(
      .IDLE_THROTTLE (IDLE_THROTTLE)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .item   (item),
      .gain   (gain_ff),
      .result (result)
   );

   // ---- output register ----
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (ctl.load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rsp_tdata_ff <= {7'd0, result.roll_drive, result.pitch_drive,
                          result.yaw_drive, result.throttle_drive, result.armed};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("input accepted again while an item is in progress");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result loaded over a pending transfer");

endmodule

`default_nettype wire
